// ===== rtl/core/hlss_pkg.sv =====
// Shared types, codes and microprogram for the Heston log-spot step block.
// No dependencies; used by heston_log_spot_step.
`default_nettype none
package hlss_pkg;

  localparam int unsigned FRAC_BITS_DEF = 24;
  localparam int unsigned NUM_REGS      = 16;
  localparam int unsigned PC_W          = 6;
  localparam int unsigned EXP_TERMS     = 20;

  // Microcode operations
  localparam logic [3:0] OP_SMUL = 4'd0;   // signed product, rounded, clamped to 2^60
  localparam logic [3:0] OP_UMUL = 4'd1;   // unsigned product, rounded, capped at 2^62
  localparam logic [3:0] OP_SADD = 4'd2;
  localparam logic [3:0] OP_SSUB = 4'd3;
  localparam logic [3:0] OP_UADD = 4'd4;
  localparam logic [3:0] OP_MAX0 = 4'd5;
  localparam logic [3:0] OP_RDIV = 4'd6;   // rho / xi, toward zero
  localparam logic [3:0] OP_DIVK = 4'd7;   // A / series index
  localparam logic [3:0] OP_SQRT = 4'd8;
  localparam logic [3:0] OP_EXPN = 4'd9;   // split exponent, range checks
  localparam logic [3:0] OP_LOOP = 4'd10;
  localparam logic [3:0] OP_GOTO = 4'd11;
  localparam logic [3:0] OP_BRXI = 4'd12;  // branch when xi is zero
  localparam logic [3:0] OP_FIN  = 4'd13;

  // Operand sources: codes below 16 address the scratch registers
  localparam logic [5:0] SRC_R0     = 6'd0;
  localparam logic [5:0] SRC_R1     = 6'd1;
  localparam logic [5:0] SRC_R2     = 6'd2;
  localparam logic [5:0] SRC_R3     = 6'd3;
  localparam logic [5:0] SRC_R4     = 6'd4;
  localparam logic [5:0] SRC_R5     = 6'd5;
  localparam logic [5:0] SRC_R6     = 6'd6;
  localparam logic [5:0] SRC_R7     = 6'd7;
  localparam logic [5:0] SRC_R8     = 6'd8;
  localparam logic [5:0] SRC_R9     = 6'd9;
  localparam logic [5:0] SRC_DT     = 6'd16;
  localparam logic [5:0] SRC_TN     = 6'd17;
  localparam logic [5:0] SRC_TB     = 6'd18;
  localparam logic [5:0] SRC_VB     = 6'd19;
  localparam logic [5:0] SRC_VN     = 6'd20;
  localparam logic [5:0] SRC_Z      = 6'd21;
  localparam logic [5:0] SRC_CN     = 6'd22;
  localparam logic [5:0] SRC_CB     = 6'd23;
  localparam logic [5:0] SRC_JMP    = 6'd24;
  localparam logic [5:0] SRC_KAP    = 6'd25;
  localparam logic [5:0] SRC_TH     = 6'd26;
  localparam logic [5:0] SRC_RHO    = 6'd27;
  localparam logic [5:0] SRC_HALF   = 6'd28;
  localparam logic [5:0] SRC_ONE    = 6'd29;
  localparam logic [5:0] SRC_ZERO   = 6'd30;
  localparam logic [5:0] SRC_LOG2E  = 6'd31;
  localparam logic [5:0] SRC_LN2    = 6'd32;
  localparam logic [5:0] SRC_ONEQ60 = 6'd33;
  localparam logic [5:0] SRC_LAST   = 6'd34;
  localparam logic [5:0] SRC_K      = 6'd35;

  // Product shift selects
  localparam logic [2:0] SH_F   = 3'd0;
  localparam logic [2:0] SH_F1  = 3'd1;
  localparam logic [2:0] SH_32  = 3'd2;
  localparam logic [2:0] SH_60  = 3'd3;
  localparam logic [2:0] SH_EXP = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_KAPPA = 3'd0;
  localparam logic [2:0] CFG_THETA = 3'd1;
  localparam logic [2:0] CFG_XI    = 3'd2;
  localparam logic [2:0] CFG_RHO   = 3'd3;
  localparam logic [2:0] CFG_SPOT  = 3'd4;
  localparam logic [2:0] CFG_JUMP  = 3'd5;

  localparam logic [63:0]        LOG2E_Q32 = 64'h0000_0001_7154_7653;
  localparam logic [63:0]        LN2_Q60   = 64'h0B17_217F_7D1C_F79B;
  localparam logic [63:0]        ONE_Q60   = 64'h1000_0000_0000_0000;
  localparam logic signed [63:0] LIMIT     = 64'sh1000_0000_0000_0000;
  localparam logic [63:0]        CAP       = 64'h4000_0000_0000_0000;
  localparam logic [47:0]        SPOT_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0]        SPOT_RST  = 48'd1677721600;
  localparam logic signed [63:0] EXP_N_MIN = -64'sd67;
  localparam logic signed [63:0] EXP_N_MAX = 64'sd60;

  // Program entry points
  localparam logic [PC_W-1:0] PC_ROOT   = 6'd26;
  localparam logic [PC_W-1:0] PC_EULER  = 6'd30;
  localparam logic [PC_W-1:0] PC_COMMON = 6'd35;
  localparam logic [PC_W-1:0] PC_TERM   = 6'd41;

  typedef struct packed {
    logic [3:0]      op;
    logic [3:0]      dst;
    logic [5:0]      a;
    logic [5:0]      b;
    logic [2:0]      sh;
    logic [PC_W-1:0] tgt;
  } instr_t;

  function automatic instr_t mk(input logic [3:0] op, input logic [5:0] d,
                                input logic [5:0] a, input logic [5:0] b,
                                input logic [2:0] sh, input logic [PC_W-1:0] tgt);
    instr_t i;
    i.op  = op;
    i.dst = d[3:0];
    i.a   = a;
    i.b   = b;
    i.sh  = sh;
    i.tgt = tgt;
    return i;
  endfunction

  function automatic instr_t prog(input logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      // carry term
      6'd0:  i = mk(OP_SMUL, SRC_R0, SRC_CN, SRC_TN, SH_F, '0);
      6'd1:  i = mk(OP_SMUL, SRC_R1, SRC_CB, SRC_TB, SH_F, '0);
      6'd2:  i = mk(OP_SSUB, SRC_R0, SRC_R0, SRC_R1, SH_F, '0);
      6'd3:  i = mk(OP_BRXI, SRC_R0, SRC_ZERO, SRC_ZERO, SH_F, PC_EULER);
      // Andersen coefficients
      6'd4:  i = mk(OP_RDIV, SRC_R2, SRC_ZERO, SRC_ZERO, SH_F, '0);
      6'd5:  i = mk(OP_SMUL, SRC_R3, SRC_KAP, SRC_R2, SH_F, '0);
      6'd6:  i = mk(OP_SSUB, SRC_R3, SRC_R3, SRC_HALF, SH_F, '0);
      6'd7:  i = mk(OP_SMUL, SRC_R3, SRC_DT, SRC_R3, SH_F1, '0);
      6'd8:  i = mk(OP_SMUL, SRC_R4, SRC_KAP, SRC_TH, SH_F, '0);
      6'd9:  i = mk(OP_SMUL, SRC_R4, SRC_R4, SRC_R2, SH_F, '0);
      6'd10: i = mk(OP_SMUL, SRC_R4, SRC_R4, SRC_DT, SH_F, '0);
      6'd11: i = mk(OP_SSUB, SRC_R4, SRC_ZERO, SRC_R4, SH_F, '0);
      6'd12: i = mk(OP_SSUB, SRC_R5, SRC_R3, SRC_R2, SH_F, '0);
      6'd13: i = mk(OP_SADD, SRC_R6, SRC_R3, SRC_R2, SH_F, '0);
      6'd14: i = mk(OP_SMUL, SRC_R7, SRC_RHO, SRC_RHO, SH_F, '0);
      6'd15: i = mk(OP_SSUB, SRC_R7, SRC_ONE, SRC_R7, SH_F, '0);
      6'd16: i = mk(OP_SMUL, SRC_R7, SRC_DT, SRC_R7, SH_F1, '0);
      6'd17: i = mk(OP_SMUL, SRC_R8, SRC_R7, SRC_VB, SH_F, '0);
      6'd18: i = mk(OP_SMUL, SRC_R9, SRC_R7, SRC_VN, SH_F, '0);
      6'd19: i = mk(OP_SADD, SRC_R8, SRC_R8, SRC_R9, SH_F, '0);
      6'd20: i = mk(OP_MAX0, SRC_R8, SRC_R8, SRC_ZERO, SH_F, '0);
      6'd21: i = mk(OP_SADD, SRC_R0, SRC_R0, SRC_R4, SH_F, '0);
      6'd22: i = mk(OP_SMUL, SRC_R9, SRC_R5, SRC_VB, SH_F, '0);
      6'd23: i = mk(OP_SADD, SRC_R0, SRC_R0, SRC_R9, SH_F, '0);
      6'd24: i = mk(OP_SMUL, SRC_R9, SRC_R6, SRC_VN, SH_F, '0);
      6'd25: i = mk(OP_SADD, SRC_R0, SRC_R0, SRC_R9, SH_F, '0);
      // diffusion term, shared by both schemes
      6'd26: i = mk(OP_SQRT, SRC_R8, SRC_R8, SRC_ZERO, SH_F, '0);
      6'd27: i = mk(OP_SMUL, SRC_R9, SRC_R8, SRC_Z, SH_F, '0);
      6'd28: i = mk(OP_SADD, SRC_R0, SRC_R0, SRC_R9, SH_F, '0);
      6'd29: i = mk(OP_GOTO, SRC_R0, SRC_ZERO, SRC_ZERO, SH_F, PC_COMMON);
      // plain log-Euler
      6'd30: i = mk(OP_SMUL, SRC_R8, SRC_VB, SRC_DT, SH_F, '0);
      6'd31: i = mk(OP_MAX0, SRC_R8, SRC_R8, SRC_ZERO, SH_F, '0);
      6'd32: i = mk(OP_SMUL, SRC_R9, SRC_VB, SRC_DT, SH_F1, '0);
      6'd33: i = mk(OP_SSUB, SRC_R0, SRC_R0, SRC_R9, SH_F, '0);
      6'd34: i = mk(OP_GOTO, SRC_R0, SRC_ZERO, SRC_ZERO, SH_F, PC_ROOT);
      // jump, then exponential
      6'd35: i = mk(OP_SADD, SRC_R0, SRC_R0, SRC_JMP, SH_F, '0);
      6'd36: i = mk(OP_SMUL, SRC_R0, SRC_R0, SRC_LOG2E, SH_32, '0);
      6'd37: i = mk(OP_EXPN, SRC_R1, SRC_R0, SRC_ZERO, SH_F, '0);
      6'd38: i = mk(OP_UMUL, SRC_R1, SRC_R1, SRC_LN2, SH_F, '0);
      6'd39: i = mk(OP_UADD, SRC_R2, SRC_ONEQ60, SRC_ZERO, SH_F, '0);
      6'd40: i = mk(OP_UADD, SRC_R3, SRC_ONEQ60, SRC_ZERO, SH_F, '0);
      6'd41: i = mk(OP_UMUL, SRC_R3, SRC_R3, SRC_R1, SH_60, '0);
      6'd42: i = mk(OP_DIVK, SRC_R3, SRC_R3, SRC_K, SH_F, '0);
      6'd43: i = mk(OP_UADD, SRC_R2, SRC_R2, SRC_R3, SH_F, '0);
      6'd44: i = mk(OP_LOOP, SRC_R0, SRC_ZERO, SRC_ZERO, SH_F, PC_TERM);
      6'd45: i = mk(OP_UMUL, SRC_R2, SRC_LAST, SRC_R2, SH_EXP, '0);
      6'd46: i = mk(OP_FIN, SRC_R0, SRC_R2, SRC_ZERO, SH_F, '0);
      default: i = mk(OP_FIN, SRC_R0, SRC_ZERO, SRC_ZERO, SH_F, '0);
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/heston_log_spot_step.sv =====
// Top level of the Heston log-spot step: microcoded datapath, APB registers, handshakes.
// Depends on hlss_pkg (operation codes, operand codes, microprogram).
`default_nettype none
// One transaction advances one Monte Carlo path's spot by one date. A first-date
// transaction returns the configured initial spot and stores it as the path's
// last spot. Every other transaction runs a microprogram on one shared
// arithmetic datapath: a 1-bit-per-cycle shift-add multiplier followed by
// rounding and saturation steps, a restoring divider and a restoring square
// root, each instruction passing through fetch and execute states. For the
// Andersen scheme (nonzero xi) and plain log-Euler alike, the multiplier and
// divider loops set the run time, the 20-term exponential series being most of
// it. The input stalls from acceptance until the result is placed in the output
// register; the next transaction is taken while that result still waits
// downstream. Configuration registers are 64-bit APB words at byte address
// 8*index, to be written only while idle by the user; the block does not enforce it.
module heston_log_spot_step #(
  parameter int unsigned FRAC_BITS = hlss_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               first_date_i,
  input  logic [30:0]        step_length_i,
  input  logic [30:0]        time_now_i,
  input  logic [30:0]        time_before_i,
  input  logic signed [31:0] variance_before_i,
  input  logic signed [31:0] variance_now_i,
  input  logic signed [31:0] normal_draw_i,
  input  logic signed [31:0] carry_rate_now_i,
  input  logic signed [31:0] carry_rate_before_i,
  input  logic signed [31:0] jump_increment_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [47:0]        spot_value_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam logic [6:0]  SH_F_V  = 7'(FRAC_BITS);
  localparam logic [6:0]  SH_F1_V = 7'(FRAC_BITS + 1);
  localparam logic [6:0]  SH_32_V = 7'd32;
  localparam logic [6:0]  SH_60_V = 7'd60;
  localparam logic [63:0] ONE_V   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF_V  = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] FR_MASK = ONE_V - 64'd1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FETCH = 4'd1;
  localparam logic [3:0] ST_EXEC  = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_RND   = 4'd4;
  localparam logic [3:0] ST_SHF   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  // configuration
  logic [31:0]        kap_q, th_q, xi_q;
  logic signed [25:0] rho_q;
  logic [47:0]        init_q;
  logic               jen_q;

  // captured transaction
  logic [30:0]        dt_q, tn_q, tb_q;
  logic signed [31:0] vb_q, vn_q, z_q, cn_q, cb_q, jmp_q;

  // sequencer
  logic [3:0]                  state_q;
  logic [hlss_pkg::PC_W-1:0]   pc_q;
  logic [4:0]                  k_q;
  logic [5:0]                  cnt_q;
  logic [6:0]                  sh_exp_q;
  logic [47:0]                 last_q, res_q, out_q;
  logic                        out_valid_q;
  hlss_pkg::instr_t            ins;

  // scratch registers
  logic [63:0] rf_q [hlss_pkg::NUM_REGS];
  logic [63:0] rd_a_q, rd_b_q;
  logic        rf_we;
  logic [63:0] rf_wd;

  // multiplier
  logic [63:0]  ma_q, mb_q;
  logic [127:0] acc_q;
  logic [6:0]   mul_sh_q;
  logic         mul_neg_q, mul_sgn_q;
  logic [64:0]  msum;
  logic [127:0] rnd_add, shifted;
  logic [63:0]  ucap, smag, mres;

  // divider
  logic [63:0] dvd_q;
  logic [31:0] dsr_q;
  logic [32:0] rem_q, rem_sh;
  logic        div_neg_q, div_ge;
  logic [63:0] quot;

  // square root
  logic [95:0] rad_q;
  logic [51:0] sq_rem_q, sq_sh, sq_trial;
  logic [47:0] root_q, root_nx;
  logic        sq_ge;

  // operands and combinational results
  logic signed [63:0] opa, opb, n_val;
  logic [63:0]        sum_ab, dif_ab, uadd_ab, max0_a;
  logic [6:0]         sh_v;
  logic [25:0]        rho_mag;
  logic               accept, cfg_we;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign spot_value_o = out_q;
  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite;
  assign ins        = hlss_pkg::prog(pc_q);

  function automatic logic signed [63:0] clampv(input logic signed [63:0] v);
    if (v > hlss_pkg::LIMIT) return hlss_pkg::LIMIT;
    if (v < -hlss_pkg::LIMIT) return -hlss_pkg::LIMIT;
    return v;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    return clampv(clampv(a) + clampv(b));
  endfunction

  function automatic logic [63:0] src_val(input logic [5:0] s);
    logic [63:0] v;
    unique case (s)
      hlss_pkg::SRC_DT:     v = {33'd0, dt_q};
      hlss_pkg::SRC_TN:     v = {33'd0, tn_q};
      hlss_pkg::SRC_TB:     v = {33'd0, tb_q};
      hlss_pkg::SRC_VB:     v = 64'(vb_q);
      hlss_pkg::SRC_VN:     v = 64'(vn_q);
      hlss_pkg::SRC_Z:      v = 64'(z_q);
      hlss_pkg::SRC_CN:     v = 64'(cn_q);
      hlss_pkg::SRC_CB:     v = 64'(cb_q);
      hlss_pkg::SRC_JMP:    v = jen_q ? 64'(jmp_q) : 64'd0;
      hlss_pkg::SRC_KAP:    v = {32'd0, kap_q};
      hlss_pkg::SRC_TH:     v = {32'd0, th_q};
      hlss_pkg::SRC_RHO:    v = 64'(rho_q);
      hlss_pkg::SRC_HALF:   v = HALF_V;
      hlss_pkg::SRC_ONE:    v = ONE_V;
      hlss_pkg::SRC_LOG2E:  v = hlss_pkg::LOG2E_Q32;
      hlss_pkg::SRC_LN2:    v = hlss_pkg::LN2_Q60;
      hlss_pkg::SRC_ONEQ60: v = hlss_pkg::ONE_Q60;
      hlss_pkg::SRC_LAST:   v = {16'd0, last_q};
      hlss_pkg::SRC_K:      v = {59'd0, k_q};
      default:              v = 64'd0;
    endcase
    return v;
  endfunction

  // operand select and combinational ALU
  always_comb begin
    opa     = (ins.a[5:4] == 2'b00) ? rd_a_q : src_val(ins.a);
    opb     = (ins.b[5:4] == 2'b00) ? rd_b_q : src_val(ins.b);
    sum_ab  = sadd(opa, opb);
    dif_ab  = sadd(opa, -opb);
    uadd_ab = opa + opb;
    max0_a  = opa[63] ? 64'd0 : opa;
    n_val   = opa >>> FRAC_BITS;
    rho_mag = rho_q[25] ? 26'(-rho_q) : 26'(rho_q);
    unique case (ins.sh)
      hlss_pkg::SH_F:   sh_v = SH_F_V;
      hlss_pkg::SH_F1:  sh_v = SH_F1_V;
      hlss_pkg::SH_32:  sh_v = SH_32_V;
      hlss_pkg::SH_60:  sh_v = SH_60_V;
      hlss_pkg::SH_EXP: sh_v = sh_exp_q;
      default:          sh_v = SH_F_V;
    endcase
  end

  // multiplier step, rounding and saturation
  always_comb begin
    msum    = {1'b0, acc_q[127:64]} + (mb_q[0] ? {1'b0, ma_q} : 65'd0);
    rnd_add = (mul_sh_q != 7'd0) ? (128'd1 << (mul_sh_q - 7'd1)) : 128'd0;
    shifted = acc_q >> mul_sh_q;
    ucap    = ((shifted[127:64] != 64'd0) || (shifted[63:0] > hlss_pkg::CAP))
              ? hlss_pkg::CAP : shifted[63:0];
    smag    = (ucap > 64'(hlss_pkg::LIMIT)) ? 64'(hlss_pkg::LIMIT) : ucap;
    mres    = mul_sgn_q ? (mul_neg_q ? -smag : smag) : ucap;
  end

  // divider and root steps
  always_comb begin
    rem_sh   = {rem_q[31:0], dvd_q[63]};
    div_ge   = (rem_sh >= {1'b0, dsr_q});
    quot     = {dvd_q[62:0], div_ge};
    sq_sh    = {sq_rem_q[49:0], rad_q[95:94]};
    sq_trial = {2'b00, root_q, 2'b01};
    sq_ge    = (sq_sh >= sq_trial);
    root_nx  = {root_q[46:0], sq_ge};
  end

  // write-back
  always_comb begin
    rf_we = 1'b0;
    rf_wd = 64'd0;
    unique case (state_q)
      ST_EXEC: begin
        unique case (ins.op)
          hlss_pkg::OP_SADD: begin rf_we = 1'b1; rf_wd = sum_ab; end
          hlss_pkg::OP_SSUB: begin rf_we = 1'b1; rf_wd = dif_ab; end
          hlss_pkg::OP_UADD: begin rf_we = 1'b1; rf_wd = uadd_ab; end
          hlss_pkg::OP_MAX0: begin rf_we = 1'b1; rf_wd = max0_a; end
          hlss_pkg::OP_EXPN: begin rf_we = 1'b1; rf_wd = opa & FR_MASK; end
          default: ;
        endcase
      end
      ST_SHF: begin
        rf_we = 1'b1;
        rf_wd = mres;
      end
      ST_DIV: begin
        rf_we = (cnt_q == 6'd0);
        rf_wd = div_neg_q ? -quot : quot;
      end
      ST_SQRT: begin
        rf_we = (cnt_q == 6'd0);
        rf_wd = {16'd0, root_nx};
      end
      default: ;
    endcase
  end

  // scratch register file: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[ins.dst] <= rf_wd;
    end
    if (state_q == ST_FETCH) begin
      rd_a_q <= rf_q[ins.a[3:0]];
      rd_b_q <= rf_q[ins.b[3:0]];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kap_q  <= '0;
      th_q   <= '0;
      xi_q   <= '0;
      rho_q  <= '0;
      init_q <= hlss_pkg::SPOT_RST;
      jen_q  <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[5:3])
        hlss_pkg::CFG_KAPPA: kap_q  <= pwdata[31:0];
        hlss_pkg::CFG_THETA: th_q   <= pwdata[31:0];
        hlss_pkg::CFG_XI:    xi_q   <= pwdata[31:0];
        hlss_pkg::CFG_RHO:   rho_q  <= pwdata[25:0];
        hlss_pkg::CFG_SPOT:  init_q <= pwdata[47:0];
        hlss_pkg::CFG_JUMP:  jen_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      hlss_pkg::CFG_KAPPA: prdata = {32'd0, kap_q};
      hlss_pkg::CFG_THETA: prdata = {32'd0, th_q};
      hlss_pkg::CFG_XI:    prdata = {32'd0, xi_q};
      hlss_pkg::CFG_RHO:   prdata = 64'(rho_q);
      hlss_pkg::CFG_SPOT:  prdata = {16'd0, init_q};
      hlss_pkg::CFG_JUMP:  prdata = {63'd0, jen_q};
      default:             prdata = 64'd0;
    endcase
  end

  // captured fields and datapath registers (no reset needed)
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q  <= step_length_i;
      tn_q  <= time_now_i;
      tb_q  <= time_before_i;
      vb_q  <= variance_before_i;
      vn_q  <= variance_now_i;
      z_q   <= normal_draw_i;
      cn_q  <= carry_rate_now_i;
      cb_q  <= carry_rate_before_i;
      jmp_q <= jump_increment_i;
    end
    unique case (state_q)
      ST_EXEC: begin
        unique case (ins.op)
          hlss_pkg::OP_SMUL: begin
            ma_q      <= opa[63] ? -opa : opa;
            mb_q      <= opb[63] ? -opb : opb;
            mul_neg_q <= opa[63] ^ opb[63];
            mul_sgn_q <= 1'b1;
            mul_sh_q  <= sh_v;
            acc_q     <= '0;
          end
          hlss_pkg::OP_UMUL: begin
            ma_q      <= opa;
            mb_q      <= opb;
            mul_neg_q <= 1'b0;
            mul_sgn_q <= 1'b0;
            mul_sh_q  <= sh_v;
            acc_q     <= '0;
          end
          hlss_pkg::OP_RDIV: begin
            dvd_q     <= {38'd0, rho_mag} << FRAC_BITS;
            dsr_q     <= xi_q;
            div_neg_q <= rho_q[25];
            rem_q     <= '0;
          end
          hlss_pkg::OP_DIVK: begin
            dvd_q     <= opa;
            dsr_q     <= {27'd0, k_q};
            div_neg_q <= 1'b0;
            rem_q     <= '0;
          end
          hlss_pkg::OP_SQRT: begin
            rad_q    <= {32'd0, opa} << FRAC_BITS;
            sq_rem_q <= '0;
            root_q   <= '0;
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        acc_q <= {msum, acc_q[63:1]};
        mb_q  <= {1'b0, mb_q[63:1]};
      end
      ST_RND: acc_q <= acc_q + rnd_add;
      ST_DIV: begin
        rem_q <= div_ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
        dvd_q <= quot;
      end
      ST_SQRT: begin
        sq_rem_q <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
        root_q   <= root_nx;
        rad_q    <= {rad_q[93:0], 2'b00};
      end
      default: ;
    endcase
  end

  // sequencer, path state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      sh_exp_q    <= '0;
      last_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result loads the free (or draining) slot, otherwise the slot drains
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pc_q <= '0;
            if (first_date_i) begin
              res_q   <= init_q;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_FETCH;
            end
          end
        end
        ST_FETCH: state_q <= ST_EXEC;
        ST_EXEC: begin
          unique case (ins.op)
            hlss_pkg::OP_SMUL, hlss_pkg::OP_UMUL: begin
              cnt_q   <= 6'd63;
              state_q <= ST_MUL;
            end
            hlss_pkg::OP_RDIV, hlss_pkg::OP_DIVK: begin
              cnt_q   <= 6'd63;
              state_q <= ST_DIV;
            end
            hlss_pkg::OP_SQRT: begin
              cnt_q   <= 6'd47;
              state_q <= ST_SQRT;
            end
            hlss_pkg::OP_EXPN: begin
              // exponent range and a zero spot end the transaction early
              k_q <= 5'd1;
              if (last_q == 48'd0 || n_val < hlss_pkg::EXP_N_MIN) begin
                res_q   <= '0;
                state_q <= ST_OUT;
              end else if (n_val > hlss_pkg::EXP_N_MAX) begin
                res_q   <= hlss_pkg::SPOT_MAX;
                state_q <= ST_OUT;
              end else begin
                sh_exp_q <= 7'(hlss_pkg::EXP_N_MAX - n_val);
                pc_q     <= pc_q + 1'b1;
                state_q  <= ST_FETCH;
              end
            end
            hlss_pkg::OP_LOOP: begin
              if (k_q < 5'(hlss_pkg::EXP_TERMS)) begin
                k_q  <= k_q + 5'd1;
                pc_q <= ins.tgt;
              end else begin
                pc_q <= pc_q + 1'b1;
              end
              state_q <= ST_FETCH;
            end
            hlss_pkg::OP_GOTO: begin
              pc_q    <= ins.tgt;
              state_q <= ST_FETCH;
            end
            hlss_pkg::OP_BRXI: begin
              pc_q    <= (xi_q == 32'd0) ? ins.tgt : pc_q + 1'b1;
              state_q <= ST_FETCH;
            end
            hlss_pkg::OP_FIN: begin
              res_q   <= (opa > {16'd0, hlss_pkg::SPOT_MAX}) ? hlss_pkg::SPOT_MAX
                                                             : opa[47:0];
              state_q <= ST_OUT;
            end
            default: begin
              pc_q    <= pc_q + 1'b1;
              state_q <= ST_FETCH;
            end
          endcase
        end
        ST_MUL: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            state_q <= ST_RND;
          end
        end
        ST_RND: state_q <= ST_SHF;
        ST_SHF: begin
          pc_q    <= pc_q + 1'b1;
          state_q <= ST_FETCH;
        end
        ST_DIV, ST_SQRT: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            pc_q    <= pc_q + 1'b1;
            state_q <= ST_FETCH;
          end
        end
        ST_OUT: begin
          // wait for a free output slot
          if (!out_valid_q || !out_stall_i) begin
            out_q   <= res_q;
            last_q  <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== bench/heston_log_spot_step_checker.sv =====
// Scoreboard for heston_log_spot_step: mirrors the APB registers, predicts each spot.
// Depends on hlss_pkg for register indexes and constants; no other files.
module heston_log_spot_step_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               first_date_i,
  input  logic [30:0]        step_length_i,
  input  logic [30:0]        time_now_i,
  input  logic [30:0]        time_before_i,
  input  logic signed [31:0] variance_before_i,
  input  logic signed [31:0] variance_now_i,
  input  logic signed [31:0] normal_draw_i,
  input  logic signed [31:0] carry_rate_now_i,
  input  logic signed [31:0] carry_rate_before_i,
  input  logic signed [31:0] jump_increment_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [47:0]        spot_value_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               pready,
  output int                 error_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB = hlss_pkg::FRAC_BITS_DEF;

  logic [31:0]        kappa_q, theta_q, xi_q;
  longint             rho_q;
  logic [47:0]        init_spot_q;
  logic               jump_en_q;
  logic [47:0]        path_spot_q;
  logic [47:0]        spot_queue[$];

  function automatic logic [63:0] umul_round(logic [63:0] a, logic [63:0] b, int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (sh > 0) p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    if (p > {64'd0, hlss_pkg::CAP}) return hlss_pkg::CAP;
    return p[63:0];
  endfunction

  function automatic longint clamp60(longint v);
    if (v > hlss_pkg::LIMIT) return hlss_pkg::LIMIT;
    if (v < -hlss_pkg::LIMIT) return -hlss_pkg::LIMIT;
    return v;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clamp60(clamp60(a) + clamp60(b));
  endfunction

  function automatic logic [63:0] magnitude(longint a);
    return (a < 0) ? 64'd0 - 64'(a) : 64'(a);
  endfunction

  function automatic longint mul_sat(longint a, longint b, int unsigned sh);
    logic        neg;
    logic [63:0] r;
    neg = (a < 0) != (b < 0);
    r = umul_round(magnitude(a), magnitude(b), sh);
    if (r > 64'(hlss_pkg::LIMIT)) r = 64'(hlss_pkg::LIMIT);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // floor(sqrt(x * 2^FB))
  function automatic longint root_floor(longint x);
    logic [127:0] target;
    logic [63:0]  y, c;
    target = {64'd0, 64'(x)} << FB;
    y = 0;
    for (int b = 46; b >= 0; b--) begin
      c = y | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= target) y = c;
    end
    return longint'(y);
  endfunction

  // prev * exp(step): 2^n exactly times a 20-term series for the fractional part
  function automatic logic [47:0] grow_spot(logic [47:0] prev, longint step);
    longint      y, n;
    logic [63:0] fr, u, sum, term, r;
    y = mul_sat(step, longint'(hlss_pkg::LOG2E_Q32), 32);
    fr = 64'(y) & ((64'd1 << FB) - 1);
    n = y >>> FB;
    if (prev == 0 || n < -67) return '0;
    if (n > 60) return hlss_pkg::SPOT_MAX;
    u = umul_round(fr, hlss_pkg::LN2_Q60, FB);
    sum = hlss_pkg::ONE_Q60;
    term = hlss_pkg::ONE_Q60;
    for (int k = 1; k <= hlss_pkg::EXP_TERMS; k++) begin
      term = umul_round(term, u, 60) / k;
      sum = sum + term;
    end
    r = umul_round({16'd0, prev}, sum, 60 - int'(n));
    return (r > {16'd0, hlss_pkg::SPOT_MAX}) ? hlss_pkg::SPOT_MAX : r[47:0];
  endfunction

  function automatic logic [47:0] next_spot();
    longint one_v, half_v, dt, vb, vn, z, carry, step;
    longint kap, th, r, a, k0, k1, k2, k3, var_v, vdt;
    logic [63:0] q;
    one_v = longint'(1) << FB;
    half_v = longint'(1) << (FB - 1);
    if (first_date_i) return init_spot_q;
    dt = longint'(step_length_i);
    vb = longint'(variance_before_i);
    vn = longint'(variance_now_i);
    z = longint'(normal_draw_i);
    carry = add_sat(mul_sat(longint'(carry_rate_now_i), longint'(time_now_i), FB),
                    -mul_sat(longint'(carry_rate_before_i), longint'(time_before_i), FB));
    if (xi_q != 0) begin
      // Andersen central scheme
      kap = longint'(kappa_q);
      th = longint'(theta_q);
      q = (magnitude(rho_q) << FB) / xi_q;
      r = (rho_q < 0) ? -longint'(q) : longint'(q);
      a = mul_sat(dt, add_sat(mul_sat(kap, r, FB), -half_v), FB + 1);
      k0 = -mul_sat(mul_sat(mul_sat(kap, th, FB), r, FB), dt, FB);
      k1 = add_sat(a, -r);
      k2 = add_sat(a, r);
      k3 = mul_sat(dt, add_sat(one_v, -mul_sat(rho_q, rho_q, FB)), FB + 1);
      var_v = add_sat(mul_sat(k3, vb, FB), mul_sat(k3, vn, FB));
      if (var_v < 0) var_v = 0;
      step = add_sat(carry, k0);
      step = add_sat(step, mul_sat(k1, vb, FB));
      step = add_sat(step, mul_sat(k2, vn, FB));
      step = add_sat(step, mul_sat(root_floor(var_v), z, FB));
    end else begin
      // log-Euler fallback
      vdt = mul_sat(vb, dt, FB);
      if (vdt < 0) vdt = 0;
      step = add_sat(carry, -mul_sat(vb, dt, FB + 1));
      step = add_sat(step, mul_sat(root_floor(vdt), z, FB));
    end
    if (jump_en_q) step = add_sat(step, longint'(jump_increment_i));
    return grow_spot(path_spot_q, step);
  endfunction

  assign pending_o = spot_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [47:0] exp_spot;
    if (!rst_ni) begin
      kappa_q = 0;
      theta_q = 0;
      xi_q = 0;
      rho_q = 0;
      init_spot_q = hlss_pkg::SPOT_RST;
      jump_en_q = 0;
      path_spot_q = 0;
      error_count_o = 0;
      spot_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          hlss_pkg::CFG_KAPPA: kappa_q = pwdata[31:0];
          hlss_pkg::CFG_THETA: theta_q = pwdata[31:0];
          hlss_pkg::CFG_XI:    xi_q = pwdata[31:0];
          hlss_pkg::CFG_RHO:   rho_q = longint'($signed(pwdata[25:0]));
          hlss_pkg::CFG_SPOT:  init_spot_q = pwdata[47:0];
          hlss_pkg::CFG_JUMP:  jump_en_q = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        exp_spot = next_spot();
        path_spot_q = exp_spot;
        spot_queue.insert(spot_queue.size(), exp_spot);
      end
      if (out_valid_i && !out_stall_i) begin
        if (spot_queue.size() == 0) begin
          $display("%0t unexpected spot: expected none actual %h", $time, spot_value_i);
          error_count_o++;
        end else begin
          exp_spot = spot_queue.pop_front();
          if (spot_value_i !== exp_spot) begin
            $display("%0t spot mismatch: expected %h actual %h", $time, exp_spot, spot_value_i);
            error_count_o++;
          end
        end
      end
    end
  end
endmodule

// ===== bench/tb_heston_log_spot_step.sv =====
// Testbench top for heston_log_spot_step: clock, reset, APB setup, stimulus, verdict.
// Depends on hlss_pkg, the block and heston_log_spot_step_checker.
module tb_heston_log_spot_step;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the register list, writes must be ignored
  localparam logic [2:0] CFG_UNUSED = 3'd6;
  // covers one step plus long stalls and gaps
  localparam int WATCHDOG_CYCLES = 40000;
  localparam int RAND_PHASES     = 8;
  localparam int PHASE_ITEMS     = 245;

  typedef struct {
    logic               first;
    logic [30:0]        dt, tn, tb;
    logic signed [31:0] vb, vn, z, cn, cb, jmp;
  } date_t;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic               first_date_i = 0;
  logic [30:0]        step_length_i = 0, time_now_i = 0, time_before_i = 0;
  logic signed [31:0] variance_before_i = 0, variance_now_i = 0, normal_draw_i = 0;
  logic signed [31:0] carry_rate_now_i = 0, carry_rate_before_i = 0, jump_increment_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic [47:0]        spot_value_o;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [5:0]         paddr = 0;
  logic [63:0]        pwdata = 0;
  logic [63:0]        prdata;
  logic               pready;
  int                 error_count, pending_spots;
  int                 idle_cycles = 0;
  int                 stall_left = 0;
  logic               stall_on = 0;

  heston_log_spot_step DUT (.*);

  heston_log_spot_step_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .first_date_i,
    .step_length_i, .time_now_i, .time_before_i, .variance_before_i, .variance_now_i,
    .normal_draw_i, .carry_rate_now_i, .carry_rate_before_i, .jump_increment_i,
    .out_valid_i(out_valid_o), .out_stall_i, .spot_value_i(spot_value_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .error_count_o(error_count), .pending_o(pending_spots)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Downstream back-pressure: quiet stretches, short stalls, the odd long one
  always @(posedge clk_i) begin
    int pick;
    if (stall_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        stall_on = 0;
        stall_left = $urandom_range(1, 200);
      end else if (pick < 88) begin
        stall_on = 1;
        stall_left = $urandom_range(1, 3);
      end else begin
        stall_on = 1;
        stall_left = $urandom_range(20, 300);
      end
    end
    stall_left--;
    out_stall_i <= stall_on;
  end

  // Watchdog: no transaction on either channel for too long ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Registers change only with the path idle; the task waits on the clock first so the last
  // accepted transaction shows up in the stall and the pending count
  task automatic wait_drained();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending_spots != 0 || in_stall_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_model(input logic [31:0] kap, input logic [31:0] th,
                           input logic [31:0] xi, input logic [25:0] rho,
                           input logic [47:0] spot, input logic jmp_en);
    wait_drained();
    reg_write(hlss_pkg::CFG_KAPPA, {32'd0, kap});
    reg_write(hlss_pkg::CFG_THETA, {32'd0, th});
    reg_write(hlss_pkg::CFG_XI, {32'd0, xi});
    reg_write(hlss_pkg::CFG_RHO, {{38{rho[25]}}, rho});
    reg_write(hlss_pkg::CFG_SPOT, {16'd0, spot});
    reg_write(hlss_pkg::CFG_JUMP, {63'd0, jmp_en});
    reg_write(CFG_UNUSED, {$urandom, $urandom});
  endtask

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  // valid stays high across back-to-back transactions; lowered for a gap or while draining
  task automatic send_date(input date_t d, input int gap);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    first_date_i <= d.first;
    step_length_i <= d.dt;
    time_now_i <= d.tn;
    time_before_i <= d.tb;
    variance_before_i <= d.vb;
    variance_now_i <= d.vn;
    normal_draw_i <= d.z;
    carry_rate_now_i <= d.cn;
    carry_rate_before_i <= d.cb;
    jump_increment_i <= d.jmp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic date_t make_date(input int first, input int dt,
                                     input int tn, input int tb,
                                     input int vb, input int vn, input int z,
                                     input int cn, input int cb, input int jmp);
    date_t d;
    d.first = (first != 0);
    d.dt = 31'(dt);
    d.tn = 31'(tn);
    d.tb = 31'(tb);
    d.vb = vb;
    d.vn = vn;
    d.z = z;
    d.cn = cn;
    d.cb = cb;
    d.jmp = jmp;
    return d;
  endfunction

  function automatic int small_signed(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly plausible market paths; some raw noise over the full field ranges
  function automatic date_t random_date();
    date_t d;
    int    t;
    if ($urandom_range(0, 99) < 72) begin
      t = int'($urandom_range(0, 1 << 27));
      d = make_date(int'($urandom_range(0, 99) < 4), int'($urandom_range(1 << 18, 1 << 22)),
                    t + int'($urandom_range(1 << 18, 1 << 22)), t,
                    small_signed(1 << 23) + (1 << 22), small_signed(1 << 23) + (1 << 22),
                    small_signed(3 << 24), small_signed(1 << 22), small_signed(1 << 22),
                    small_signed(1 << 22));
    end else begin
      d = make_date(int'($urandom_range(0, 99) < 10), $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    return d;
  endfunction

  task automatic random_model();
    logic [31:0] kap, th, xi;
    logic [25:0] rho;
    logic [47:0] spot;
    kap = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1 << 23, 5 << 24);
    th = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1 << 19, 1 << 23);
    case ($urandom_range(0, 4))
      0: xi = 0;
      1: xi = $urandom;
      default: xi = $urandom_range(1 << 22, 1 << 24);
    endcase
    rho = ($urandom_range(0, 4) == 0) ? 26'($urandom)
                                       : 26'(small_signed(1 << 24));
    spot = ($urandom_range(0, 4) == 0) ? 48'({$urandom, $urandom})
                                       : 48'($urandom_range(1 << 24, 1 << 31));
    set_model(kap, th, xi, rho, spot, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Reset settings: xi zero, so log-Euler; no first date yet, spot reads zero
    send_date(random_date(), 0);
    send_date(make_date(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_date(make_date(0, 1 << 22, 1 << 24, 0, 1 << 22, 1 << 22, 1 << 24, 1 << 21, 0, 0), 0);
    // negative variance: value under the root floors at zero
    send_date(make_date(0, 1 << 22, 0, 0, -(1 << 22), 0, 1 << 24, 0, 0, 0), 2);
    send_date(make_date(0, '1, '1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0);
    send_date(make_date(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_date(make_date(0, 0, 0, '1, 0, 0, 0, 0, 32'h7FFF_FFFF, 0), 0);

    // Typical Andersen settings with jumps enabled
    set_model(32'h0200_0000, 32'h000A_3D71, 32'h0080_0000, 26'(-11744051),
              48'h0064_0000_0000, 1'b1);
    send_date(make_date(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_date(make_date(0, 1 << 22, 1 << 22, 0, 1 << 20, 1 << 20, -(1 << 24), 1 << 20, 0,
                        1 << 20), 0);
    send_date(make_date(0, 1 << 22, 0, 0, -(1 << 24), -(1 << 24), 1 << 24, 0, 0, 0), 1);
    // big jump up: exponential overflows and the spot saturates, then stays high
    send_date(make_date(0, 1 << 20, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF), 0);
    send_date(make_date(0, 1 << 20, 0, 0, 1 << 20, 1 << 20, 0, 0, 0, 0), 0);
    send_date(make_date(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    // big jump down: underflow to zero, and zero stays zero
    send_date(make_date(0, 1 << 20, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000), 0);
    send_date(make_date(0, 1 << 20, 0, 0, 1 << 20, 1 << 20, 1 << 24, 0, 0, 1 << 24), 0);

    // Extreme registers: rho at one, smallest xi
    set_model('1, '1, 32'd1, 26'(1 << 24), hlss_pkg::SPOT_MAX, 1'b0);
    send_date(make_date(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_date(make_date(0, '1, 0, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 0), 0);
    send_date(make_date(0, 1 << 22, 1 << 24, 0, 1 << 22, 1 << 22, 1 << 23, 0, 0, 0), 0);

    // Correlation past minus one, widest xi, zero kappa and theta
    set_model(0, 0, '1, 26'h200_0000, 48'h0001_0000_0000, 1'b1);
    send_date(make_date(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_date(make_date(0, 1 << 24, 1 << 24, 1 << 23, 1 << 22, 1 << 23, 1 << 24,
                        1 << 20, 1 << 20, 1 << 20), 0);
    send_date(make_date(0, 1 << 22, 0, 0, 1 << 22, 1 << 22, -(1 << 24), 0, 0, -(1 << 20)), 0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_model();
      send_date(make_date(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // now and then hold off until the path has fully drained
        if ($urandom_range(0, 99) == 0) begin
          wait_drained();
        end
        send_date(random_date(), pick_gap());
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
